>>> design/i2cbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, counter widths and the request/response word types.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

   localparam int DATA_W        = 8;
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_COUNT_W   = $clog2(BITS_PER_BYTE + 1);
   localparam int MODE_W        = 3;
   localparam int HALF_W        = 16;

   localparam logic [MODE_W-1:0] MODE_START    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STOP     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ACKSEND  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ACKCHECK = 3'd5;

   localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd5;

   typedef logic [BIT_COUNT_W-1:0] bit_count_type;

   typedef struct packed {
      logic              cmd_valid;
      logic [MODE_W-1:0] mode;
      logic [DATA_W-1:0] tx_byte;
      logic              ack_bit;
      logic              sda_in;
   } req_type;

   typedef struct packed {
      logic              scl_out;
      logic              sda_release;
      logic              busy_res;
      logic              done_res;
      logic [DATA_W-1:0] rx_byte;
      logic              rx_ack;
   } rsp_type;

endpackage

>>> design/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// Each response word is registered straight from its accepted request word.
// Throughput: one word per cycle unless a held response word stalls it; each word
// is one line tick, with state update and response register in a single pass.
// Reset: synchronous, active high; lines released high, sequencer idle,
// half period back to 5, received byte and ack cleared.
// ----------------------------------------------------------------------------
// I2C master bit engine
// Sequences SCL/SDA for start, stop, byte write/read and ack send/check,
// one request word per line tick, one response word per tick.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  i2cbe_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output i2cbe_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [i2cbe_pkg::HALF_W-1:0]          csr_wr_data
);
   import i2cbe_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SECOND, PH_THIRD} phase_type;

   phase_type         phase_ff, phase_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   bit_count_type     bit_count_ff, bit_count_in;
   logic [HALF_W-1:0] wait_ff, wait_in;
   logic [DATA_W-1:0] shift_ff, shift_in;
   logic [DATA_W-1:0] rx_data_ff, rx_data_in;
   logic              scl_ff, scl_in;
   logic              sda_ff, sda_in_lvl;
   logic              ack_seen_ff, ack_seen_in;
   logic [HALF_W-1:0] half_period_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              done_in;
   logic [HALF_W-1:0] wait_load;
   bit_count_type     bit_count_inc;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a zero half period still waits one tick
   assign wait_load     = (half_period_ff == '0) ? HALF_W'(1) : half_period_ff;
   assign bit_count_inc = bit_count_ff + BIT_COUNT_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      bit_count_in = bit_count_ff;
      wait_in      = wait_ff;
      shift_in     = shift_ff;
      rx_data_in   = rx_data_ff;
      scl_in       = scl_ff;
      sda_in_lvl   = sda_ff;
      ack_seen_in  = ack_seen_ff;
      done_in      = 1'b0;

      if (phase_ff != PH_IDLE) begin
         if (wait_ff > HALF_W'(1)) begin
            wait_in = wait_ff - HALF_W'(1);
         end else begin
            wait_in = '0;
            case (mode_ff)
               MODE_START: begin
                  if (phase_ff == PH_FIRST) begin
                     sda_in_lvl = 1'b0;
                     wait_in    = wait_load;
                     phase_in   = PH_SECOND;
                  end else begin
                     scl_in  = 1'b0;
                     done_in = 1'b1;
                  end
               end
               MODE_STOP: begin
                  if (phase_ff == PH_FIRST) begin
                     sda_in_lvl = 1'b1;
                     wait_in    = wait_load;
                     phase_in   = PH_SECOND;
                  end else begin
                     done_in = 1'b1;
                  end
               end
               MODE_ACKSEND, MODE_ACKCHECK: begin
                  if (phase_ff == PH_FIRST) begin
                     scl_in   = 1'b1;
                     wait_in  = wait_load;
                     phase_in = PH_SECOND;
                  end else begin
                     if (mode_ff == MODE_ACKCHECK) begin
                        ack_seen_in = req_data.sda_in;
                     end
                     scl_in  = 1'b0;
                     done_in = 1'b1;
                  end
               end
               MODE_WRITE: begin
                  if (phase_ff == PH_FIRST) begin
                     sda_in_lvl = shift_ff[DATA_W-1];
                     wait_in    = wait_load;
                     phase_in   = PH_SECOND;
                  end else if (phase_ff == PH_SECOND) begin
                     scl_in   = 1'b1;
                     wait_in  = wait_load;
                     phase_in = PH_THIRD;
                  end else begin
                     shift_in     = {shift_ff[DATA_W-2:0], 1'b0};
                     bit_count_in = bit_count_inc;
                     scl_in       = 1'b0;
                     if (bit_count_inc >= BIT_COUNT_W'(BITS_PER_BYTE)) begin
                        done_in = 1'b1;
                     end else begin
                        wait_in  = wait_load;
                        phase_in = PH_FIRST;
                     end
                  end
               end
               default: begin
                  // read byte: sample SDA after SCL has been high one wait
                  if (phase_ff == PH_FIRST) begin
                     scl_in   = 1'b1;
                     wait_in  = wait_load;
                     phase_in = PH_SECOND;
                  end else begin
                     shift_in     = {shift_ff[DATA_W-2:0], req_data.sda_in};
                     bit_count_in = bit_count_inc;
                     scl_in       = 1'b0;
                     if (bit_count_inc >= BIT_COUNT_W'(BITS_PER_BYTE)) begin
                        rx_data_in = {shift_ff[DATA_W-2:0], req_data.sda_in};
                        done_in    = 1'b1;
                     end else begin
                        wait_in  = wait_load;
                        phase_in = PH_FIRST;
                     end
                  end
               end
            endcase
            if (done_in) begin
               phase_in = PH_IDLE;
            end
         end
      end else if (req_data.cmd_valid && req_data.mode <= MODE_ACKCHECK) begin
         mode_in      = req_data.mode;
         bit_count_in = '0;
         wait_in      = wait_load;
         phase_in     = PH_FIRST;
         case (req_data.mode)
            MODE_START: begin
               scl_in     = 1'b1;
               sda_in_lvl = 1'b1;
            end
            MODE_STOP: begin
               scl_in     = 1'b1;
               sda_in_lvl = 1'b0;
            end
            MODE_WRITE: begin
               shift_in = req_data.tx_byte;
               scl_in   = 1'b0;
            end
            MODE_READ: begin
               sda_in_lvl = 1'b1;
               scl_in     = 1'b0;
            end
            MODE_ACKSEND: begin
               scl_in     = 1'b0;
               sda_in_lvl = req_data.ack_bit;
            end
            default: begin
               sda_in_lvl = 1'b1;
               scl_in     = 1'b0;
            end
         endcase
      end

      rsp_data_in.scl_out     = scl_in;
      rsp_data_in.sda_release = sda_in_lvl;
      rsp_data_in.busy_res    = (phase_in != PH_IDLE);
      rsp_data_in.done_res    = done_in;
      rsp_data_in.rx_byte     = rx_data_in;
      rsp_data_in.rx_ack      = ack_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         mode_ff        <= MODE_START;
         bit_count_ff   <= '0;
         wait_ff        <= '0;
         shift_ff       <= '0;
         rx_data_ff     <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         ack_seen_ff    <= 1'b0;
         half_period_ff <= HALF_PERIOD_RESET;
         rsp_valid_ff   <= 1'b0;
         rsp_data_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            half_period_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff     <= phase_in;
            mode_ff      <= mode_in;
            bit_count_ff <= bit_count_in;
            wait_ff      <= wait_in;
            shift_ff     <= shift_in;
            rx_data_ff   <= rx_data_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in_lvl;
            ack_seen_ff  <= ack_seen_in;
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
         end else if (!rsp_stall) begin
            // drop the word once taken
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef ASSERT_OFF
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("request stalled with empty response register");

   a_wait_loaded: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (wait_ff != '0))
      else $error("sequencer busy with no wait loaded");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BIT_COUNT_W'(BITS_PER_BYTE))
      else $error("bit counter overran the byte");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && done_in) |=> (phase_ff == PH_IDLE && !rsp_data_ff.busy_res))
      else $error("command completed but sequencer not idle");

   a_line_change_on_expiry: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff != PH_IDLE && wait_ff > 16'd1) |=> $stable(scl_ff))
      else $error("SCL moved while a wait was still counting");
`endif

endmodule

>>> verif/i2c_master_bit_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives line ticks through the request channel and predicts the SCL/SDA
// levels, busy/done flags, received byte and ack of every response word.
// Directed command runs at the period extremes, then random traffic under
// random idling, a long response hold-off and drains between phases.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
   import i2cbe_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 100000;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_LEAD, SEQ_MID, SEQ_TAIL} seq_phase_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [HALF_W-1:0]  csr_wr_data = '0;

   // line sequencer prediction state
   logic [HALF_W-1:0]  half_q = HALF_PERIOD_RESET;
   seq_phase_type      seq_phase = SEQ_IDLE;
   logic [MODE_W-1:0]  cur_mode = '0;
   logic [3:0]         bits_done = '0;
   logic [HALF_W-1:0]  wait_left = '0;
   logic [DATA_W-1:0]  shift_q = '0;
   logic [DATA_W-1:0]  rx_q = '0;
   logic               scl_q = 1'b1;
   logic               sda_q = 1'b1;
   logic               ack_q = 1'b0;

   rsp_type            line_states_due[$];
   int unsigned        mismatch_count = 0;
   int unsigned        cycles = 0;
   bit                 steady = 1'b0;
   int                 hold_off_request = 0;

   i2c_master_bit_engine uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("i2c_master_bit_engine_tb: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t ns mismatch on %s: expected %0h, got %0h", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic arm_wait(input seq_phase_type nxt);
      wait_left = (half_q == '0) ? 16'd1 : half_q;
      seq_phase = nxt;
   endtask

   // Advance the predicted sequencer by one tick and queue the word it shows.
   task automatic predict_line_tick(input req_type w);
      rsp_type r;
      logic    finished;
      finished = 1'b0;
      if (seq_phase != SEQ_IDLE) begin
         if (wait_left > 1) begin
            wait_left--;
         end else begin
            wait_left = '0;
            case (cur_mode)
               MODE_START: begin
                  if (seq_phase == SEQ_LEAD) begin
                     sda_q = 1'b0;
                     arm_wait(SEQ_MID);
                  end else begin
                     scl_q = 1'b0;
                     finished = 1'b1;
                  end
               end
               MODE_STOP: begin
                  if (seq_phase == SEQ_LEAD) begin
                     sda_q = 1'b1;
                     arm_wait(SEQ_MID);
                  end else begin
                     finished = 1'b1;
                  end
               end
               MODE_ACKSEND, MODE_ACKCHECK: begin
                  if (seq_phase == SEQ_LEAD) begin
                     scl_q = 1'b1;
                     arm_wait(SEQ_MID);
                  end else begin
                     if (cur_mode == MODE_ACKCHECK) ack_q = w.sda_in;
                     scl_q = 1'b0;
                     finished = 1'b1;
                  end
               end
               MODE_WRITE: begin
                  if (seq_phase == SEQ_LEAD) begin
                     sda_q = shift_q[DATA_W-1];
                     arm_wait(SEQ_MID);
                  end else if (seq_phase == SEQ_MID) begin
                     scl_q = 1'b1;
                     arm_wait(SEQ_TAIL);
                  end else begin
                     shift_q = shift_q << 1;
                     bits_done++;
                     scl_q = 1'b0;
                     if (bits_done >= BITS_PER_BYTE) finished = 1'b1;
                     else arm_wait(SEQ_LEAD);
                  end
               end
               default: begin
                  // read: sample on the tick SCL has been high a full wait
                  if (seq_phase == SEQ_LEAD) begin
                     scl_q = 1'b1;
                     arm_wait(SEQ_MID);
                  end else begin
                     shift_q = {shift_q[DATA_W-2:0], w.sda_in};
                     bits_done++;
                     scl_q = 1'b0;
                     if (bits_done >= BITS_PER_BYTE) begin
                        rx_q = shift_q;
                        finished = 1'b1;
                     end else begin
                        arm_wait(SEQ_LEAD);
                     end
                  end
               end
            endcase
            if (finished) seq_phase = SEQ_IDLE;
         end
      end else if (w.cmd_valid && w.mode <= MODE_ACKCHECK) begin
         cur_mode = w.mode;
         bits_done = '0;
         case (w.mode)
            MODE_START:   begin scl_q = 1'b1; sda_q = 1'b1; end
            MODE_STOP:    begin scl_q = 1'b1; sda_q = 1'b0; end
            MODE_WRITE:   begin shift_q = w.tx_byte; scl_q = 1'b0; end
            MODE_READ:    begin sda_q = 1'b1; scl_q = 1'b0; end
            MODE_ACKSEND: begin scl_q = 1'b0; sda_q = w.ack_bit; end
            default:      begin sda_q = 1'b1; scl_q = 1'b0; end
         endcase
         arm_wait(SEQ_LEAD);
      end
      r.scl_out     = scl_q;
      r.sda_release = sda_q;
      r.busy_res    = (seq_phase != SEQ_IDLE);
      r.done_res    = finished;
      r.rx_byte     = rx_q;
      r.rx_ack      = ack_q;
      line_states_due.push_back(r);
   endtask

   function automatic req_type make_word(input logic valid, input logic [MODE_W-1:0] mode,
                                         input logic [DATA_W-1:0] tx, input logic ack,
                                         input logic sda);
      req_type w;
      w.cmd_valid = valid;
      w.mode      = mode;
      w.tx_byte   = tx;
      w.ack_bit   = ack;
      w.sda_in    = sda;
      return w;
   endfunction

   task automatic send_tick(input req_type w);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_line_tick(w);
   endtask

   // Drop valid and hold until every queued word has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (line_states_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_half_period(input logic [HALF_W-1:0] value);
      drain();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      half_q = value;
      csr_wr_en <= 1'b0;
   endtask

   // Issue one command, then tick until it completes. Busy ticks carry random
   // commands that the block must ignore. sda_sel: 0 or 1 fixed, else random.
   task automatic run_command(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] tx,
                              input logic ack, input int sda_sel);
      logic sda;
      sda = (sda_sel > 1) ? 1'($urandom_range(0, 1)) : 1'(sda_sel);
      send_tick(make_word(1'b1, mode, tx, ack, sda));
      while (seq_phase != SEQ_IDLE) begin
         sda = (sda_sel > 1) ? 1'($urandom_range(0, 1)) : 1'(sda_sel);
         send_tick(make_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                             8'($urandom), 1'($urandom_range(0, 1)), sda));
      end
   endtask

   task automatic test_default_period();
      run_command(MODE_START, 8'h00, 1'b0, 2);
      run_command(MODE_ACKCHECK, 8'h00, 1'b0, 2);
   endtask

   task automatic test_every_command();
      write_half_period(16'd1);
      run_command(MODE_START, 8'h00, 1'b0, 2);
      run_command(MODE_WRITE, 8'hFF, 1'b1, 2);
      run_command(MODE_WRITE, 8'h00, 1'b0, 2);
      run_command(MODE_READ, 8'h00, 1'b0, 1);
      run_command(MODE_READ, 8'h00, 1'b0, 0);
      run_command(MODE_ACKSEND, 8'h00, 1'b0, 2);
      run_command(MODE_ACKSEND, 8'h00, 1'b1, 2);
      run_command(MODE_ACKCHECK, 8'h00, 1'b0, 0);
      run_command(MODE_ACKCHECK, 8'h00, 1'b0, 1);
      // undefined modes and an unflagged command leave the block idle
      send_tick(make_word(1'b1, 3'd6, 8'hFF, 1'b1, 1'b1));
      send_tick(make_word(1'b1, 3'd7, 8'h00, 1'b0, 1'b0));
      send_tick(make_word(1'b0, MODE_WRITE, 8'h5A, 1'b1, 1'b0));
      run_command(MODE_STOP, 8'h00, 1'b0, 2);
   endtask

   task automatic test_zero_period();
      write_half_period(16'd0);
      run_command(MODE_WRITE, 8'hA5, 1'b0, 2);
      run_command(MODE_READ, 8'h00, 1'b0, 2);
   endtask

   // Long first wait, cut short for later waits by a mid-command rewrite.
   task automatic test_long_period();
      steady = 1'b1;
      write_half_period(16'd40);
      send_tick(make_word(1'b1, MODE_START, 8'h00, 1'b0, 1'b1));
      write_half_period(16'd3);
      while (seq_phase != SEQ_IDLE)
         send_tick(make_word(1'b0, MODE_STOP, 8'h00, 1'b0, 1'($urandom_range(0, 1))));
      steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      logic [HALF_W-1:0] hp;
      req_type           w;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0:       hp = 16'd0;
            1:       hp = 16'd1;
            2:       hp = 16'd2;
            default: hp = 16'($urandom_range(1, 6));
         endcase
         write_half_period(hp);
         steady = (ph == 3);
         for (int n = 0; n < 140; n++) begin
            w = make_word(1'b0, 3'($urandom_range(0, 5)), 8'($urandom),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (seq_phase == SEQ_IDLE) begin
               w.cmd_valid = ($urandom_range(0, 7) != 0);
               if ($urandom_range(0, 9) == 0) w.mode = 3'($urandom_range(6, 7));
            end else begin
               w.cmd_valid = ($urandom_range(0, 3) == 0);
            end
            send_tick(w);
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_backpressure();
      write_half_period(16'd1);
      hold_off_request = 40;
      run_command(MODE_WRITE, 8'($urandom), 1'b0, 2);
      run_command(MODE_READ, 8'h00, 1'b0, 2);
      drain();
      run_command(MODE_ACKCHECK, 8'h00, 1'b0, 2);
   endtask

   // Response side: random hold per word, or one long hold-off on request.
   initial begin : rsp_side
      int hold;
      forever begin
         if (hold_off_request != 0) begin
            hold = hold_off_request;
            hold_off_request = 0;
         end else begin
            hold = steady ? 0 : $urandom_range(0, 3);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset || !(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_states_due.size() == 0) begin
            report_mismatch("unexpected word", '0, 32'(rsp_data));
         end else begin
            want = line_states_due.pop_front();
            if (rsp_data.scl_out !== want.scl_out)
               report_mismatch("scl_out", 32'(want.scl_out), 32'(rsp_data.scl_out));
            if (rsp_data.sda_release !== want.sda_release)
               report_mismatch("sda_release", 32'(want.sda_release),
                               32'(rsp_data.sda_release));
            if (rsp_data.busy_res !== want.busy_res)
               report_mismatch("busy_res", 32'(want.busy_res), 32'(rsp_data.busy_res));
            if (rsp_data.done_res !== want.done_res)
               report_mismatch("done_res", 32'(want.done_res), 32'(rsp_data.done_res));
            if (rsp_data.rx_byte !== want.rx_byte)
               report_mismatch("rx_byte", 32'(want.rx_byte), 32'(rsp_data.rx_byte));
            if (rsp_data.rx_ack !== want.rx_ack)
               report_mismatch("rx_ack", 32'(want.rx_ack), 32'(rsp_data.rx_ack));
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_period();
      test_every_command();
      test_zero_period();
      test_long_period();
      test_random_traffic();
      test_backpressure();
      drain();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("i2c_master_bit_engine_tb: PASS");
      end else begin
         $display("i2c_master_bit_engine_tb: FAIL");
      end
      $finish;
   end

endmodule
